// File: rtl/quaternion_vector_rotate_assert.svh
// Assertion forms shared by the rotate pipeline.
// Both sample on clk and stay off while rst_n is low.
`ifndef QUATERNION_VECTOR_ROTATE_ASSERT_SVH
`define QUATERNION_VECTOR_ROTATE_ASSERT_SVH

// Same-cycle implication.
`define QVR_ASSERT_HOLDS(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define QVR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/qvr_pkg.sv
`timescale 1ns / 1ps
package qvr_pkg;

  localparam int QW             = 32;
  localparam int MW             = 34;
  localparam int PW             = 64;
  localparam int PBW            = 66;
  localparam int RW             = 36;
  localparam int SW             = 38;
  localparam int NOPS           = 9;
  localparam int QUAT_FRAC_BITS = 30;

  localparam longint MID_LIM = 64'sd8589934591;

  localparam logic [1:0] MODE_ROT     = 2'd0;
  localparam logic [1:0] MODE_INV     = 2'd1;
  localparam logic [1:0] MODE_MAT     = 2'd2;
  localparam logic [1:0] MODE_MAT_ALT = 2'd3;

  typedef logic signed [QW-1:0] word_t;
  typedef logic signed [MW-1:0] mid_t;

  typedef struct packed {
    logic [1:0] mode;
    word_t      quat_w;
    word_t      quat_x;
    word_t      quat_y;
    word_t      quat_z;
    word_t      vec_x;
    word_t      vec_y;
    word_t      vec_z;
  } qvr_in_t;

  typedef struct packed {
    word_t res_x;
    word_t res_y;
    word_t res_z;
    logic  saturated;
  } qvr_out_t;

  // Operand set for the second multiply bank, row-major by result component.
  typedef struct packed {
    logic                  mat;
    logic                  neg;
    logic                  sat;
    word_t                 vec_x;
    word_t                 vec_y;
    word_t                 vec_z;
    word_t [NOPS-1:0]      op_a;
    mid_t  [NOPS-1:0]      op_b;
  } qvr_op_t;

  // Round to nearest, ties away from zero, then drop s fraction bits.
  function automatic logic signed [PBW-1:0] round_shift(input logic signed [PBW-1:0] x,
                                                        input int unsigned s);
    logic signed [PBW-1:0] bias;
    bias = {{(PBW-1){1'b0}}, 1'b1} << (s - 1);
    bias = bias - {{(PBW-1){1'b0}}, x[PBW-1]};
    return (x + bias) >>> s;
  endfunction

endpackage

// File: rtl/quaternion_vector_rotate.sv
`timescale 1ns / 1ps
// Channel   Ports                          Payload
// input     in_valid, in_ready, in_data    qvr_in_t  (mode, quat_w..z, vec_x..z)
// result    out_valid, out_ready, out_data qvr_out_t (res_x..z, saturated)
//
// One transfer per cycle sustained while out_ready stays high; out_valid rises once the
// input transfer has passed through every stage register listed below.
// Stages: product bank, rounding, t/matrix clip, second product bank, rounding,
// row sum and clip into the output register.
// rst_n is synchronous and clears the stage valid bits only.
// A stall holds each full stage; empty stages ahead of it keep filling.
module quaternion_vector_rotate (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  qvr_pkg::qvr_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output qvr_pkg::qvr_out_t out_data
);
  import qvr_pkg::*;

  logic    op_valid;
  logic    op_ready;
  qvr_op_t op_data;

  qvr_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .op_valid (op_valid),
    .op_ready (op_ready),
    .op_data  (op_data)
  );

  qvr_apply u_apply (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (op_valid),
    .up_ready  (op_ready),
    .up_data   (op_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: rtl/qvr_prep.sv
`timescale 1ns / 1ps
`include "quaternion_vector_rotate_assert.svh"
module qvr_prep (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  qvr_pkg::qvr_in_t in_data,
  output logic             op_valid,
  input  logic             op_ready,
  output qvr_pkg::qvr_op_t op_data
);
  import qvr_pkg::*;

  localparam int NPROD = 10;

  // Matrix entries from rounded products: w*w, x*x, y*y, z*z, w*x, w*y, w*z, x*y, x*z, y*z
  localparam int unsigned ENT_A [NOPS] = '{0, 7, 8, 7, 0, 9, 8, 9, 0};
  localparam int unsigned ENT_B [NOPS] = '{1, 6, 5, 6, 2, 4, 5, 4, 3};
  localparam logic [NOPS-1:0] ENT_SUB  = 9'b001100010;
  localparam logic [NOPS-1:0] ENT_DIAG = 9'b100010001;

  // Rotation operands: quaternion part index (w,x,y,z) and t index.
  localparam int unsigned ROT_QI [NOPS] = '{0, 2, 3, 0, 3, 1, 0, 1, 2};
  localparam int unsigned ROT_TI [NOPS] = '{0, 2, 1, 1, 0, 2, 2, 1, 0};

  localparam logic signed [RW-1:0] LIM_R = RW'(MID_LIM);
  localparam logic signed [SW-1:0] LIM_S = SW'(MID_LIM);
  localparam logic signed [SW-1:0] ONE_S = SW'(longint'(1) << QUAT_FRAC_BITS);

  logic s1_en, s2_en, s3_en;
  logic s1_valid_r, s2_valid_r, s3_valid_r;
  logic s1_mat_r, s1_neg_r, s2_mat_r, s2_neg_r;
  word_t s1_q_r [4];
  word_t s1_v_r [3];
  word_t s2_q_r [4];
  word_t s2_v_r [3];
  logic signed [PW-1:0] s1_prod_r   [NPROD];
  logic signed [PW-1:0] s1_prod_nxt [NPROD];
  logic signed [RW-1:0] s2_rnd_r    [NPROD];
  logic signed [RW-1:0] s2_rnd_nxt  [NPROD];
  qvr_op_t s3_op_r, s3_op_nxt;

  word_t in_q [4];
  word_t in_v [3];
  word_t ma [6];
  word_t mb [6];
  logic in_mat, in_neg;
  logic op_b_sign;

  assign s3_en    = !s3_valid_r || op_ready;
  assign s2_en    = !s2_valid_r || s3_en;
  assign s1_en    = !s1_valid_r || s2_en;
  assign in_ready = s1_en;
  assign op_valid = s3_valid_r;
  assign op_data  = s3_op_r;

  // Stage 1: first multiply bank, shared between modes.
  always_comb begin
    in_q[0] = in_data.quat_w;
    in_q[1] = in_data.quat_x;
    in_q[2] = in_data.quat_y;
    in_q[3] = in_data.quat_z;
    in_v[0] = in_data.vec_x;
    in_v[1] = in_data.vec_y;
    in_v[2] = in_data.vec_z;
    in_mat  = (in_data.mode == MODE_MAT) || (in_data.mode == MODE_MAT_ALT);
    in_neg  = (in_data.mode == MODE_INV);
    if (in_mat) begin
      ma[0] = in_q[0]; mb[0] = in_q[0];
      ma[1] = in_q[1]; mb[1] = in_q[1];
      ma[2] = in_q[2]; mb[2] = in_q[2];
      ma[3] = in_q[3]; mb[3] = in_q[3];
      ma[4] = in_q[0]; mb[4] = in_q[1];
      ma[5] = in_q[0]; mb[5] = in_q[2];
    end else begin
      ma[0] = in_q[2]; mb[0] = in_v[2];
      ma[1] = in_q[3]; mb[1] = in_v[1];
      ma[2] = in_q[3]; mb[2] = in_v[0];
      ma[3] = in_q[1]; mb[3] = in_v[2];
      ma[4] = in_q[1]; mb[4] = in_v[1];
      ma[5] = in_q[2]; mb[5] = in_v[0];
    end
    for (int k = 0; k < 6; k++) begin
      s1_prod_nxt[k] = ma[k] * mb[k];
    end
    s1_prod_nxt[6] = in_q[0] * in_q[3];
    s1_prod_nxt[7] = in_q[1] * in_q[2];
    s1_prod_nxt[8] = in_q[1] * in_q[3];
    s1_prod_nxt[9] = in_q[2] * in_q[3];
  end

  // Stage 2: cross differences or plain products, rounded.
  always_comb begin
    logic signed [PBW-1:0] dif;
    logic signed [PBW-1:0] rd;
    logic signed [PBW-1:0] rm;
    for (int k = 0; k < NPROD; k++) begin
      rm = round_shift(PBW'(s1_prod_r[k]), QUAT_FRAC_BITS);
      s2_rnd_nxt[k] = rm[RW-1:0];
    end
    for (int i = 0; i < 3; i++) begin
      dif = PBW'(s1_prod_r[2*i]) - PBW'(s1_prod_r[2*i+1]);
      rd  = round_shift(dif, QUAT_FRAC_BITS - 1);
      if (!s1_mat_r) begin
        s2_rnd_nxt[i] = rd[RW-1:0];
      end
    end
  end

  // Stage 3: clipped t or absolute matrix entries, then operand routing.
  always_comb begin
    logic signed [RW-1:0] c;
    logic signed [SW-1:0] sm;
    logic signed [SW-1:0] m;
    logic signed [SW-1:0] am;
    mid_t t [3];
    mid_t ent [NOPS];
    logic t_sat;
    logic ent_sat;
    t_sat   = 1'b0;
    ent_sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      c = s2_neg_r ? -s2_rnd_r[i] : s2_rnd_r[i];
      if (c > LIM_R) begin
        c     = LIM_R;
        t_sat = 1'b1;
      end else if (c < -LIM_R) begin
        c     = -LIM_R;
        t_sat = 1'b1;
      end
      t[i] = c[MW-1:0];
    end
    for (int j = 0; j < NOPS; j++) begin
      if (ENT_SUB[j]) begin
        sm = SW'(s2_rnd_r[ENT_A[j]]) - SW'(s2_rnd_r[ENT_B[j]]);
      end else begin
        sm = SW'(s2_rnd_r[ENT_A[j]]) + SW'(s2_rnd_r[ENT_B[j]]);
      end
      m  = ENT_DIAG[j] ? (sm <<< 1) - ONE_S : (sm <<< 1);
      am = m[SW-1] ? -m : m;
      if (am > LIM_S) begin
        am      = LIM_S;
        ent_sat = 1'b1;
      end
      ent[j] = am[MW-1:0];
    end
    s3_op_nxt       = '0;
    s3_op_nxt.mat   = s2_mat_r;
    s3_op_nxt.neg   = s2_neg_r;
    s3_op_nxt.vec_x = s2_v_r[0];
    s3_op_nxt.vec_y = s2_v_r[1];
    s3_op_nxt.vec_z = s2_v_r[2];
    if (s2_mat_r) begin
      s3_op_nxt.sat = ent_sat;
      for (int j = 0; j < NOPS; j++) begin
        s3_op_nxt.op_a[j] = s2_v_r[j % 3];
        s3_op_nxt.op_b[j] = ent[j];
      end
    end else begin
      s3_op_nxt.sat = t_sat;
      for (int j = 0; j < NOPS; j++) begin
        s3_op_nxt.op_a[j] = s2_q_r[ROT_QI[j]];
        s3_op_nxt.op_b[j] = t[ROT_TI[j]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (s1_en) s1_valid_r <= in_valid;
      if (s2_en) s2_valid_r <= s1_valid_r;
      if (s3_en) s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && in_valid) begin
      s1_mat_r  <= in_mat;
      s1_neg_r  <= in_neg;
      s1_q_r    <= in_q;
      s1_v_r    <= in_v;
      s1_prod_r <= s1_prod_nxt;
    end
    if (s2_en && s1_valid_r) begin
      s2_mat_r <= s1_mat_r;
      s2_neg_r <= s1_neg_r;
      s2_q_r   <= s1_q_r;
      s2_v_r   <= s1_v_r;
      s2_rnd_r <= s2_rnd_nxt;
    end
    if (s3_en && s2_valid_r) begin
      s3_op_r <= s3_op_nxt;
    end
  end

  always_comb begin
    op_b_sign = 1'b0;
    for (int j = 0; j < NOPS; j++) begin
      op_b_sign = op_b_sign | s3_op_r.op_b[j][MW-1];
    end
  end

  `QVR_ASSERT_NEXT(a_in_lands, in_valid && in_ready, s1_valid_r, "accepted transfer lost at stage 1")
  `QVR_ASSERT_HOLDS(a_mat_nonneg, s3_valid_r && s3_op_r.mat, !op_b_sign, "negative matrix entry")

endmodule

// File: rtl/qvr_apply.sv
`timescale 1ns / 1ps
`include "quaternion_vector_rotate_assert.svh"
module qvr_apply (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  qvr_pkg::qvr_op_t  up_data,
  output logic              out_valid,
  input  logic              out_ready,
  output qvr_pkg::qvr_out_t out_data
);
  import qvr_pkg::*;

  localparam logic signed [SW-1:0] OUT_MAX_S = SW'(64'sd2147483647);
  localparam logic signed [SW-1:0] OUT_MIN_S = SW'(-64'sd2147483648);

  logic b1_en, b2_en, out_en;
  logic b1_valid_r, b2_valid_r, out_valid_r;
  logic b1_mat_r, b1_neg_r, b1_sat_r, b2_mat_r, b2_neg_r, b2_sat_r;
  word_t b1_v_r [3];
  word_t b2_v_r [3];
  logic signed [PBW-1:0] b1_prod_r   [NOPS];
  logic signed [PBW-1:0] b1_prod_nxt [NOPS];
  logic signed [RW-1:0]  b2_rnd_r    [NOPS];
  logic signed [RW-1:0]  b2_rnd_nxt  [NOPS];
  qvr_out_t out_data_r, out_data_nxt;

  assign out_en    = !out_valid_r || out_ready;
  assign b2_en     = !b2_valid_r || out_en;
  assign b1_en     = !b1_valid_r || b2_en;
  assign up_ready  = b1_en;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    for (int j = 0; j < NOPS; j++) begin
      b1_prod_nxt[j] = $signed(up_data.op_a[j]) * $signed(up_data.op_b[j]);
    end
  end

  always_comb begin
    logic signed [PBW-1:0] full;
    for (int j = 0; j < NOPS; j++) begin
      full          = round_shift(b1_prod_r[j], QUAT_FRAC_BITS);
      b2_rnd_nxt[j] = full[RW-1:0];
    end
  end

  // Row sums and clip to 32 bits.
  always_comb begin
    logic signed [SW-1:0] p0, p1, p2, sum;
    word_t res [3];
    logic  any_sat;
    any_sat = 1'b0;
    for (int r = 0; r < 3; r++) begin
      p0 = SW'(b2_rnd_r[3*r]);
      p1 = SW'(b2_rnd_r[3*r+1]);
      p2 = SW'(b2_rnd_r[3*r+2]);
      if (b2_mat_r) begin
        sum = p0 + p1 + p2;
      end else if (b2_neg_r) begin
        sum = SW'(b2_v_r[r]) + p0 + (p2 - p1);
      end else begin
        sum = SW'(b2_v_r[r]) + p0 + (p1 - p2);
      end
      if (sum > OUT_MAX_S) begin
        sum     = OUT_MAX_S;
        any_sat = 1'b1;
      end else if (sum < OUT_MIN_S) begin
        sum     = OUT_MIN_S;
        any_sat = 1'b1;
      end
      res[r] = sum[QW-1:0];
    end
    out_data_nxt.res_x     = res[0];
    out_data_nxt.res_y     = res[1];
    out_data_nxt.res_z     = res[2];
    out_data_nxt.saturated = b2_sat_r | any_sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r  <= 1'b0;
      b2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (b1_en)  b1_valid_r  <= up_valid;
      if (b2_en)  b2_valid_r  <= b1_valid_r;
      if (out_en) out_valid_r <= b2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b1_en && up_valid) begin
      b1_mat_r  <= up_data.mat;
      b1_neg_r  <= up_data.neg;
      b1_sat_r  <= up_data.sat;
      b1_v_r[0] <= up_data.vec_x;
      b1_v_r[1] <= up_data.vec_y;
      b1_v_r[2] <= up_data.vec_z;
      b1_prod_r <= b1_prod_nxt;
    end
    if (b2_en && b1_valid_r) begin
      b2_mat_r <= b1_mat_r;
      b2_neg_r <= b1_neg_r;
      b2_sat_r <= b1_sat_r;
      b2_v_r   <= b1_v_r;
      b2_rnd_r <= b2_rnd_nxt;
    end
    if (out_en && b2_valid_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  `QVR_ASSERT_NEXT(a_out_fill, b2_valid_r && out_en, out_valid_r, "stage 2 item not moved to output")
  `QVR_ASSERT_HOLDS(a_full_stall, b1_valid_r && b2_valid_r && out_valid_r && !out_ready, !up_ready, "full pipe took a transfer")

endmodule
